### design/multiword_multiply_assert.svh
// Assertion macros shared by the multiword multiply RTL.
`ifndef MULTIWORD_MULTIPLY_ASSERT_SVH
`define MULTIWORD_MULTIPLY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mwm_pkg.sv
// Types and constants of the multiword multiply block.
package mwm_pkg;

  localparam int MWM_WORD_CAPACITY = 32;
  localparam int WORD_W            = 32;

  typedef enum logic [1:0] {
    KIND_FIRST       = 2'd0,
    KIND_SECOND      = 2'd1,
    KIND_FIRST_ZERO  = 2'd2,
    KIND_SECOND_ZERO = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CLEAR,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_ROW_END,
    ST_TOP_RD,
    ST_TOP_CHK,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_t;

  typedef struct packed {
    logic swap;       // first operand is the shorter one (multiplier side)
    logic load_mul;
    logic clr_carry;
    logic mult;
    logic accum;
  } mac_ctl_t;

endpackage

### design/multiword_multiply.sv
// Top level of the schoolbook multiword multiplier.
//
//   channel   ports                                   handshake
//   input     in_kind, in_word, in_last               start & !busy
//   result    out_product_word, out_is_empty,         out_valid, one cycle,
//             out_overflow, out_last_res              no backpressure
//
// Once both operands are complete (n, m words), a product is computed by the single
// 32x32 MAC unit, which reads, multiplies and writes back one product RAM word in
// the states MAC_RD, MAC_MUL and MAC_ACC; only nonzero multiplier words run it.
// The product RAM is cleared by a sweep over its n+m words before each product; no
// clearing pass follows reset. busy stays high from the completing word until the
// final result is on the ports; results cannot be stalled.
`include "multiword_multiply_assert.svh"

module multiword_multiply
  import mwm_pkg::*;
#(
  parameter int WORD_CAPACITY = MWM_WORD_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [WORD_W-1:0] in_word,
  input  logic              in_last,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_product_word,
  output logic              out_is_empty,
  output logic              out_overflow,
  output logic              out_last_res
);

  localparam int AW = $clog2(WORD_CAPACITY);

  logic              a_we, b_we, p_we;
  logic [AW-1:0]     a_waddr, b_waddr, a_raddr, b_raddr, p_waddr, p_raddr;
  logic [WORD_W-1:0] a_rdata, b_rdata, p_rdata, p_wdata;
  mac_ctl_t          mac_ctl;
  logic              mul_zero;
  logic [WORD_W-1:0] sum_word, carry_word;

  mwm_ram #(.WIDTH(WORD_W), .DEPTH(WORD_CAPACITY)) u_ram_first (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (a_waddr),
    .wr_data (in_word),
    .rd_addr (a_raddr),
    .rd_data (a_rdata)
  );

  mwm_ram #(.WIDTH(WORD_W), .DEPTH(WORD_CAPACITY)) u_ram_second (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_waddr),
    .wr_data (in_word),
    .rd_addr (b_raddr),
    .rd_data (b_rdata)
  );

  mwm_ram #(.WIDTH(WORD_W), .DEPTH(WORD_CAPACITY)) u_ram_product (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .rd_addr (p_raddr),
    .rd_data (p_rdata)
  );

  mwm_mac u_mac (
    .clk        (clk),
    .ctl        (mac_ctl),
    .a_rdata    (a_rdata),
    .b_rdata    (b_rdata),
    .p_rdata    (p_rdata),
    .mul_zero   (mul_zero),
    .sum_word   (sum_word),
    .carry_word (carry_word)
  );

  mwm_seq #(.WORD_CAPACITY(WORD_CAPACITY)) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_kind          (in_kind),
    .in_last          (in_last),
    .busy             (busy),
    .a_we             (a_we),
    .b_we             (b_we),
    .a_waddr          (a_waddr),
    .b_waddr          (b_waddr),
    .a_raddr          (a_raddr),
    .b_raddr          (b_raddr),
    .p_we             (p_we),
    .p_waddr          (p_waddr),
    .p_wdata          (p_wdata),
    .p_raddr          (p_raddr),
    .p_rdata          (p_rdata),
    .mac_ctl          (mac_ctl),
    .mul_zero         (mul_zero),
    .sum_word         (sum_word),
    .carry_word       (carry_word),
    .out_valid        (out_valid),
    .out_product_word (out_product_word),
    .out_is_empty     (out_is_empty),
    .out_overflow     (out_overflow),
    .out_last_res     (out_last_res)
  );

  `MWM_ASSERT_NOW(a_result_from_busy, out_valid, $past(busy),
                  "result strobe without a product in progress")
  `MWM_ASSERT_NEXT(a_quiet_after_last, out_valid && out_last_res, !out_valid,
                   "result strobe after the final word")
  `MWM_ASSERT_NOW(a_idle_on_final, $fell(busy) && $past(rst_n),
                  out_valid && out_last_res,
                  "busy dropped without the final word")

endmodule

### design/mwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/mwm_mac.sv
// Shared 32x32 multiply-accumulate unit with carry register.
module mwm_mac
  import mwm_pkg::*;
(
  input  logic              clk,
  input  mac_ctl_t          ctl,
  input  logic [WORD_W-1:0] a_rdata,
  input  logic [WORD_W-1:0] b_rdata,
  input  logic [WORD_W-1:0] p_rdata,
  output logic              mul_zero,
  output logic [WORD_W-1:0] sum_word,
  output logic [WORD_W-1:0] carry_word
);

  logic [WORD_W-1:0]   shr_word;
  logic [WORD_W-1:0]   lng_word;
  logic [WORD_W-1:0]   mul_r;
  logic [2*WORD_W-1:0] mp_r;
  logic [WORD_W-1:0]   pp_r;
  logic [WORD_W-1:0]   carry_r;
  logic [2*WORD_W-1:0] acc;

  assign shr_word = ctl.swap ? a_rdata : b_rdata;
  assign lng_word = ctl.swap ? b_rdata : a_rdata;
  assign mul_zero = (shr_word == '0);

  // cannot overflow: (2^32-1)^2 + 2*(2^32-1) = 2^64-1
  assign acc = mp_r + (2*WORD_W)'(pp_r) + (2*WORD_W)'(carry_r);

  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      mul_r <= shr_word;
    end
    if (ctl.mult) begin
      mp_r <= (2*WORD_W)'(mul_r) * (2*WORD_W)'(lng_word);
      pp_r <= p_rdata;
    end
    if (ctl.clr_carry) begin
      carry_r <= '0;
    end else if (ctl.accum) begin
      carry_r <= acc[2*WORD_W-1:WORD_W];
    end
  end

  assign sum_word   = acc[WORD_W-1:0];
  assign carry_word = carry_r;

endmodule

### design/mwm_seq.sv
// Sequencer: operand loading, product RAM sweeps, MAC loop and result emission.
module mwm_seq
  import mwm_pkg::*;
#(
  parameter int WORD_CAPACITY = MWM_WORD_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [1:0]                       in_kind,
  input  logic                             in_last,
  output logic                             busy,
  output logic                             a_we,
  output logic                             b_we,
  output logic [$clog2(WORD_CAPACITY)-1:0] a_waddr,
  output logic [$clog2(WORD_CAPACITY)-1:0] b_waddr,
  output logic [$clog2(WORD_CAPACITY)-1:0] a_raddr,
  output logic [$clog2(WORD_CAPACITY)-1:0] b_raddr,
  output logic                             p_we,
  output logic [$clog2(WORD_CAPACITY)-1:0] p_waddr,
  output logic [WORD_W-1:0]                p_wdata,
  output logic [$clog2(WORD_CAPACITY)-1:0] p_raddr,
  input  logic [WORD_W-1:0]                p_rdata,
  output mac_ctl_t                         mac_ctl,
  input  logic                             mul_zero,
  input  logic [WORD_W-1:0]                sum_word,
  input  logic [WORD_W-1:0]                carry_word,
  output logic                             out_valid,
  output logic [WORD_W-1:0]                out_product_word,
  output logic                             out_is_empty,
  output logic                             out_overflow,
  output logic                             out_last_res
);

  localparam int AW = $clog2(WORD_CAPACITY);
  localparam int LW = $clog2(WORD_CAPACITY + 2);
  localparam logic [LW-1:0] CAP_L = LW'(WORD_CAPACITY);
  localparam logic [LW:0]   CAP_W = (LW+1)'(WORD_CAPACITY);

  state_t state_r, state_nxt;

  logic [LW-1:0] a_len_r, a_len_nxt, b_len_r, b_len_nxt;
  logic          a_done_r, a_done_nxt, b_done_r, b_done_nxt;
  logic          swap_r, swap_nxt;
  logic [LW-1:0] s_len_r, s_len_nxt, l_len_r, l_len_nxt;
  logic [LW-1:0] tot_r, tot_nxt, cnt_r, cnt_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              out_last_r, out_last_nxt;

  logic [AW-1:0] ij;
  logic [LW:0]   total_w;
  logic          i_last, j_last, k_clear_end, k_last;
  logic          len_zero, too_long;

  assign ij          = i_r + j_r;
  assign total_w     = {1'b0, a_len_r} + {1'b0, b_len_r};
  assign len_zero    = (a_len_r == '0) || (b_len_r == '0);
  assign too_long    = (total_w > CAP_W);
  assign i_last      = (LW'(i_r) == (s_len_r - 1'b1));
  assign j_last      = (LW'(j_r) == (l_len_r - 1'b1));
  assign k_clear_end = (LW'(k_r) == (tot_r - 1'b1));
  assign k_last      = (LW'(k_r) == (cnt_r - 1'b1));

  assign busy    = (state_r != ST_IDLE);
  assign a_waddr = a_len_r[AW-1:0];
  assign b_waddr = b_len_r[AW-1:0];
  // shorter operand is read at the row index, longer at the column index
  assign a_raddr = swap_r ? i_r : j_r;
  assign b_raddr = swap_r ? j_r : i_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && a_done_nxt && b_done_nxt) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (len_zero || too_long) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (k_clear_end) begin
          state_nxt = ST_ROW_RD;
        end
      end
      ST_ROW_RD:  state_nxt = ST_ROW_CHK;
      ST_ROW_CHK: begin
        if (!mul_zero) begin
          state_nxt = ST_MAC_RD;
        end else if (i_last) begin
          state_nxt = ST_TOP_RD;
        end else begin
          state_nxt = ST_ROW_RD;
        end
      end
      ST_MAC_RD:  state_nxt = ST_MAC_MUL;
      ST_MAC_MUL: state_nxt = ST_MAC_ACC;
      ST_MAC_ACC: begin
        if (j_last) begin
          state_nxt = ST_ROW_END;
        end else begin
          state_nxt = ST_MAC_RD;
        end
      end
      ST_ROW_END: begin
        if (i_last) begin
          state_nxt = ST_TOP_RD;
        end else begin
          state_nxt = ST_ROW_RD;
        end
      end
      ST_TOP_RD:  state_nxt = ST_TOP_CHK;
      ST_TOP_CHK: state_nxt = ST_OUT_RD;
      ST_OUT_RD:  state_nxt = ST_OUT_EMIT;
      ST_OUT_EMIT: begin
        if (k_last) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_OUT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs, memory controls and counters
  always_comb begin
    a_len_nxt     = a_len_r;
    b_len_nxt     = b_len_r;
    a_done_nxt    = a_done_r;
    b_done_nxt    = b_done_r;
    swap_nxt      = swap_r;
    s_len_nxt     = s_len_r;
    l_len_nxt     = l_len_r;
    tot_nxt       = tot_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    a_we          = 1'b0;
    b_we          = 1'b0;
    p_we          = 1'b0;
    p_waddr       = ij;
    p_wdata       = '0;
    p_raddr       = ij;
    mac_ctl       = '0;
    mac_ctl.swap  = swap_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '0;
    out_empty_nxt = 1'b0;
    out_ovf_nxt   = 1'b0;
    out_last_nxt  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (kind_t'(in_kind))
            KIND_FIRST: begin
              if (!a_done_r) begin
                a_we = (a_len_r < CAP_L);
                // count saturates one past capacity so overflow is seen
                if (a_len_r <= CAP_L) begin
                  a_len_nxt = a_len_r + 1'b1;
                end
                a_done_nxt = in_last;
              end
            end
            KIND_SECOND: begin
              if (!b_done_r) begin
                b_we = (b_len_r < CAP_L);
                if (b_len_r <= CAP_L) begin
                  b_len_nxt = b_len_r + 1'b1;
                end
                b_done_nxt = in_last;
              end
            end
            KIND_FIRST_ZERO: begin
              if (!a_done_r) begin
                a_len_nxt  = '0;
                a_done_nxt = 1'b1;
              end
            end
            KIND_SECOND_ZERO: begin
              if (!b_done_r) begin
                b_len_nxt  = '0;
                b_done_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DECIDE: begin
        if (len_zero || too_long) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = len_zero;
          out_ovf_nxt   = !len_zero;
          out_last_nxt  = 1'b1;
          a_len_nxt     = '0;
          b_len_nxt     = '0;
          a_done_nxt    = 1'b0;
          b_done_nxt    = 1'b0;
        end else begin
          swap_nxt  = (a_len_r < b_len_r);
          s_len_nxt = (a_len_r < b_len_r) ? a_len_r : b_len_r;
          l_len_nxt = (a_len_r < b_len_r) ? b_len_r : a_len_r;
          tot_nxt   = total_w[LW-1:0];
          k_nxt     = '0;
        end
      end
      ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = k_r;
        if (k_clear_end) begin
          i_nxt = '0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_ROW_RD: ;
      ST_ROW_CHK: begin
        mac_ctl.load_mul  = 1'b1;
        mac_ctl.clr_carry = 1'b1;
        if (!mul_zero) begin
          j_nxt = '0;
        end else if (!i_last) begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_MAC_RD: ;
      ST_MAC_MUL: begin
        mac_ctl.mult = 1'b1;
      end
      ST_MAC_ACC: begin
        mac_ctl.accum = 1'b1;
        p_we          = 1'b1;
        p_wdata       = sum_word;
        if (!j_last) begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_ROW_END: begin
        // final carry lands just above the row
        p_we    = 1'b1;
        p_waddr = i_r + AW'(l_len_r);
        p_wdata = carry_word;
        if (!i_last) begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_TOP_RD: begin
        p_raddr = AW'(tot_r - 1'b1);
      end
      ST_TOP_CHK: begin
        // drop one zero top word
        cnt_nxt = (p_rdata == '0) ? (tot_r - 1'b1) : tot_r;
        k_nxt   = '0;
      end
      ST_OUT_RD: begin
        p_raddr = k_r;
      end
      ST_OUT_EMIT: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = p_rdata;
        out_last_nxt  = k_last;
        if (k_last) begin
          a_len_nxt  = '0;
          b_len_nxt  = '0;
          a_done_nxt = 1'b0;
          b_done_nxt = 1'b0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_len_r     <= '0;
      b_len_r     <= '0;
      a_done_r    <= 1'b0;
      b_done_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_len_r     <= a_len_nxt;
      b_len_r     <= b_len_nxt;
      a_done_r    <= a_done_nxt;
      b_done_r    <= b_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    swap_r      <= swap_nxt;
    s_len_r     <= s_len_nxt;
    l_len_r     <= l_len_nxt;
    tot_r       <= tot_nxt;
    cnt_r       <= cnt_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    out_word_r  <= out_word_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_product_word = out_word_r;
  assign out_is_empty     = out_empty_r;
  assign out_overflow     = out_ovf_r;
  assign out_last_res     = out_last_r;

endmodule
